[rtl/core/jsu_pkg.sv]
// Package for the JSON string unescaper.
// Holds word kinds, parser phases, the per-byte run descriptor and the
// character helper functions. No dependencies.
package jsu_pkg;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_CLOSED = 2'd1,
    KIND_BADST  = 2'd2,
    KIND_UNTERM = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_e;

  localparam int unsigned MaxRun = 4;
  localparam int unsigned RunCntW = 3;
  localparam int unsigned RunIdxW = 2;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;

  localparam logic [15:0] Utf8Max1 = 16'h007F;
  localparam logic [15:0] Utf8Max2 = 16'h07FF;
  localparam logic [7:0]  Lead2    = 8'hC0;
  localparam logic [7:0]  Lead3    = 8'hE0;
  localparam logic [7:0]  ContMark = 8'h80;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
  } entry_t;

  typedef struct packed {
    logic [RunCntW-1:0]     cnt;
    entry_t [MaxRun-1:0]    ent;
  } run_t;

  function automatic logic [3:0] hex_value(logic [7:0] h);
    logic [3:0] v;
    v = 4'd0;
    if (h inside {[8'h30:8'h39]}) begin
      v = 4'(h - 8'h30);
    end else if (h inside {[8'h61:8'h66]}) begin
      v = 4'(h - 8'h57);
    end else if (h inside {[8'h41:8'h46]}) begin
      v = 4'(h - 8'h37);
    end
    return v;
  endfunction

  function automatic logic [7:0] escape_map(logic [7:0] e);
    logic [7:0] r;
    case (e)
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      default: r = e;
    endcase
    return r;
  endfunction

  function automatic run_t put_word(run_t r, logic [7:0] d, kind_e k);
    run_t o;
    o = r;
    o.ent[r.cnt[RunIdxW-1:0]].data = d;
    o.ent[r.cnt[RunIdxW-1:0]].kind = k;
    o.cnt = r.cnt + RunCntW'(1);
    return o;
  endfunction

endpackage

[rtl/core/json_string_unescaper.sv]
// JSON string unescaper top level: front end, run queue, back end.
// A byte's run goes into the run queue, then its first word into the output register.
// Throughput: one byte per cycle with no output stall while each byte yields at most
// one word; a byte yielding n words (up to 4, from UTF-8 or digit replay) holds the
// output for all n. Reset (async, active low) clears phase, digit count, code, queue
// and output valid; held digit bytes are not reset. Depends on jsu_pkg and submodules.
module json_string_unescaper import jsu_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_start_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_of_run_o
);

  logic push, pop, q_full, q_valid;
  run_t run_in, run_head;

  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_start_i (in_start_i),
    .in_last_i  (in_last_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .run_o      (run_in)
  );

  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .run_i   (run_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .run_o   (run_head)
  );

  jsu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_run_i       (run_head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .kind_o        (kind_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

[rtl/core/jsu_front.sv]
// Front end of the JSON string unescaper: accepts input bytes, tracks the
// string/escape/hex phase and builds the run of words each byte causes.
// Depends on jsu_pkg.
module jsu_front import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_start_i,
  input  logic       in_last_i,
  input  logic       q_full_i,
  output logic       push_o,
  output run_t       run_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] code_q, code_d;
  logic [7:0]  held_q [3];
  logic        held_we;
  logic        accept;
  run_t        run;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && (run.cnt != '0);
  assign run_o      = run;

  always_comb begin
    logic [15:0] hex_code;
    logic [2:0]  rcnt;
    logic [7:0]  c;
    logic        esc;
    logic        closed;
    phase_d   = phase_q;
    hex_cnt_d = hex_cnt_q;
    code_d    = code_q;
    held_we   = 1'b0;
    run       = '0;
    esc       = 1'b0;
    closed    = 1'b0;
    c         = '0;
    hex_code  = {code_q[11:0], hex_value(in_byte_i)};
    rcnt      = {1'b0, hex_cnt_q} + 3'd1;
    if (in_start_i) begin
      hex_cnt_d = '0;
      code_d    = '0;
      if (in_byte_i != ChQuote) begin
        run     = put_word(run, '0, KIND_BADST);
        phase_d = PH_IDLE;
      end else begin
        phase_d = PH_BODY;
        if (in_last_i) begin
          run     = put_word(run, '0, KIND_UNTERM);
          phase_d = PH_IDLE;
        end
      end
    end else begin
      case (phase_q)
        PH_BODY: begin
          if (in_byte_i == ChQuote) begin
            run     = put_word(run, '0, KIND_CLOSED);
            phase_d = PH_IDLE;
          end else if (in_byte_i == ChBslash) begin
            phase_d = PH_ESC;
          end else begin
            run = put_word(run, in_byte_i, KIND_DATA);
          end
        end
        PH_ESC: begin
          if (in_byte_i == ChU) begin
            phase_d   = PH_HEX;
            hex_cnt_d = '0;
            code_d    = '0;
          end else begin
            run     = put_word(run, escape_map(in_byte_i), KIND_DATA);
            phase_d = PH_BODY;
          end
        end
        PH_HEX: begin
          code_d = hex_code;
          if (hex_cnt_q == 2'd3) begin
            if (hex_code <= Utf8Max1) begin
              run = put_word(run, hex_code[7:0], KIND_DATA);
            end else if (hex_code <= Utf8Max2) begin
              run = put_word(run, Lead2 | {3'b000, hex_code[10:6]}, KIND_DATA);
              run = put_word(run, ContMark | {2'b00, hex_code[5:0]}, KIND_DATA);
            end else begin
              run = put_word(run, Lead3 | {4'b0000, hex_code[15:12]}, KIND_DATA);
              run = put_word(run, ContMark | {2'b00, hex_code[11:6]}, KIND_DATA);
              run = put_word(run, ContMark | {2'b00, hex_code[5:0]}, KIND_DATA);
            end
            hex_cnt_d = '0;
            code_d    = '0;
            phase_d   = PH_BODY;
          end else begin
            held_we   = 1'b1;
            hex_cnt_d = hex_cnt_q + 2'd1;
            if (in_last_i) begin
              // replay held digits plus this one as plain string text
              for (int i = 0; i < 3; i++) begin
                if ((3'(i) < rcnt) && !closed) begin
                  c = (2'(i) < hex_cnt_q) ? held_q[i] : in_byte_i;
                  if (esc) begin
                    esc = 1'b0;
                    if (c != ChU) begin
                      run = put_word(run, escape_map(c), KIND_DATA);
                    end
                  end else if (c == ChQuote) begin
                    run    = put_word(run, '0, KIND_CLOSED);
                    closed = 1'b1;
                  end else if (c == ChBslash) begin
                    esc = 1'b1;
                  end else begin
                    run = put_word(run, c, KIND_DATA);
                  end
                end
              end
              if (closed) begin
                phase_d   = PH_IDLE;
                hex_cnt_d = '0;
                code_d    = '0;
              end
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
      if (in_last_i && (phase_d != PH_IDLE)) begin
        run       = put_word(run, '0, KIND_UNTERM);
        phase_d   = PH_IDLE;
        hex_cnt_d = '0;
        code_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      hex_cnt_q <= '0;
      code_q    <= '0;
    end else if (accept) begin
      phase_q   <= phase_d;
      hex_cnt_q <= hex_cnt_d;
      code_q    <= code_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && held_we) begin
      held_q[hex_cnt_q] <= in_byte_i;
    end
  end

  a_run_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (run.cnt != '0) && (run.cnt <= RunCntW'(MaxRun)))
    else $error("run size out of range");

  a_hex_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_HEX) |-> (hex_cnt_q == '0))
    else $error("digit count held outside hex phase");

endmodule

[rtl/core/jsu_queue.sv]
// Run queue of the JSON string unescaper, between front and back end.
// Register-based FIFO of run descriptors. Depends on jsu_pkg.
module jsu_queue import jsu_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t run_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output run_t run_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  run_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign run_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= run_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

[rtl/core/jsu_back.sv]
// Back end of the JSON string unescaper: walks the head run one word per
// cycle while the output is not stalled into the output register and pops
// the run on its final word. Depends on jsu_pkg.
module jsu_back import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  run_t       q_run_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_of_run_o
);

  logic               out_valid_q, out_valid_d;
  logic [7:0]         byte_q;
  kind_e              kind_q;
  logic               last_q;
  logic [RunIdxW-1:0] idx_q, idx_d;
  logic               load;
  logic               is_last;
  entry_t             cur;

  assign load    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign cur     = q_run_i.ent[idx_q];
  assign is_last = ({1'b0, idx_q} == (q_run_i.cnt - RunCntW'(1)));
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = is_last ? '0 : idx_q + RunIdxW'(1);
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= cur.data;
      kind_q <= cur.kind;
      last_q <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign kind_o        = kind_q;
  assign last_of_run_o = last_q;

  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> ({1'b0, idx_q} < q_run_i.cnt))
    else $error("word index beyond run");

endmodule
